// ----- design/fms_pkg.sv -----
// fms_pkg: shared widths, saturation helper and twiddle generator for the
// fft magnitude spectrum unit. No dependencies.

package fms_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STORE_W  = 23;
    localparam int MAG_W    = 22;
    localparam int BIN_W    = 6;

    localparam longint Q30_ONE     = longint'(1) << 30;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // taylor series term divisors, (2n-1)(2n) for cosine and (2n)(2n+1) for sine
    localparam longint COS_DEN [10] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380};
    localparam longint SIN_DEN [10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

    typedef logic signed [STORE_W-1:0] store_t;
    typedef logic signed [STORE_W+2:0] wide_sum_t;

    // saturate a butterfly sum to the store range
    function automatic store_t sat_store(input wide_sum_t v);
        wide_sum_t hi;
        wide_sum_t lo;
        hi = wide_sum_t'((longint'(1) << (STORE_W - 1)) - 1);
        lo = -wide_sum_t'(longint'(1) << (STORE_W - 1));
        if (v > hi)
            return store_t'(hi);
        else if (v < lo)
            return store_t'(lo);
        else
            return store_t'(v);
    endfunction

    // twiddle W(k) of a 2^lg point transform, real or imaginary part
    function automatic longint fms_tw(input longint k, input int lg, input int twb,
                                      input bit imag);
        longint q;
        longint r;
        longint phi;
        longint x2;
        longint ts;
        longint tc;
        longint ss;
        longint cc;
        longint cs;
        longint sn;
        longint v;
        longint lim;
        int     sh;
        q   = (4 * k) >>> lg;
        r   = (4 * k) & ((longint'(1) << lg) - 1);
        phi = (HALF_PI_Q30 * r) >>> lg;
        x2  = (phi * phi) / Q30_ONE;
        ts  = phi;
        tc  = Q30_ONE;
        ss  = phi;
        cc  = Q30_ONE;
        for (int n = 0; n < 10; n++)
        begin
            tc = (-tc * x2) / Q30_ONE / COS_DEN[n];
            cc += tc;
            ts = (-ts * x2) / Q30_ONE / SIN_DEN[n];
            ss += ts;
        end
        if (q == 0)
        begin
            cs = cc;
            sn = ss;
        end
        else
        begin
            cs = -ss;
            sn = cc;
        end
        v   = imag ? -sn : cs;
        sh  = 30 - (twb - 1);
        v   = (v + (longint'(1) << (sh - 1))) >>> sh;
        lim = longint'(1) << (twb - 1);
        if (v < -lim)
            v = -lim;
        else if (v > lim - 1)
            v = lim - 1;
        return v;
    endfunction

endpackage

// ----- design/fms_sample_if.sv -----
// fms_sample_if: valid/ready channel that carries input samples.
// Depends on fms_pkg.

interface fms_sample_if import fms_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

// ----- design/fms_bin_if.sv -----
// fms_bin_if: valid/ready channel that carries spectrum bins.
// Depends on fms_pkg.

interface fms_bin_if import fms_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] magnitude;
    logic [BIN_W-1:0] bin;
    logic             final_bin;
    logic             truncated;

    modport source (output valid, output magnitude, output bin, output final_bin,
                    output truncated, input ready);
    modport sink   (input valid, input magnitude, input bin, input final_bin,
                    input truncated, output ready);
endinterface

// ----- design/fms_ram.sv -----
// fms_ram: generic single write, single read ram with registered read data.
// No dependencies.

module fms_ram #(
    parameter int WIDTH = 46,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ----- design/fms_isqrt.sv -----
// fms_isqrt: bit-serial integer square root, one result bit per cycle.
// No dependencies.

module fms_isqrt #(
    parameter int IN_W = 46
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [IN_W-1:0]   value,
    output logic              done,
    output logic [IN_W/2-1:0] root
);

    logic [IN_W-1:0] rem_reg;
    logic [IN_W-1:0] rem_next;
    logic [IN_W-1:0] res_reg;
    logic [IN_W-1:0] res_next;
    logic [IN_W-1:0] bit_reg;
    logic [IN_W-1:0] bit_next;
    logic            run_reg;
    logic            run_next;
    logic            done_reg;
    logic            done_next;
    logic [IN_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {1'b0, res_reg} + {1'b0, bit_reg};
        if (start)
        begin
            rem_next = value;
            res_next = '0;
            bit_next = IN_W'(1) << (IN_W - 2);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next = rem_reg - trial[IN_W-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
                res_next = res_reg >> 1;
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[IN_W/2-1:0];

endmodule

// ----- design/fft_magnitude_spectrum_unit.sv -----
// fft_magnitude_spectrum_unit: frame load, in-place radix-2 fft on one ram,
// magnitude output. Depends on fms_pkg, fms_sample_if, fms_bin_if, fms_ram, fms_isqrt.
// Samples load one per cycle in the load state. After the last sample: setup, zero pad
// to n, butterflies as read a, read b, multiply, write a, write b ((n/2)*log2 n of them,
// single ram port pair), then ram read, squares, 23-step square root for n/2+1 bins.
// Reset clears control state only; ram contents are undefined until written.

module fft_magnitude_spectrum_unit import fms_pkg::*; #(
    parameter int MAX_POINTS   = 64,
    parameter int TWIDDLE_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    fms_sample_if.sink    frame,
    fms_bin_if.source     spectrum
);

    localparam int LGMAX = $clog2(MAX_POINTS + 1) - 1;
    localparam int NMAX  = 1 << LGMAX;
    localparam int AW    = LGMAX;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int LG_W  = $clog2(LGMAX + 1);
    localparam int TWB   = TWIDDLE_BITS;
    localparam int DW    = 2 * STORE_W;
    localparam int PW    = STORE_W + TWB;
    localparam int SQ_W  = 2 * STORE_W;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_SETUP = 4'd1;
    localparam logic [3:0] S_PAD   = 4'd2;
    localparam logic [3:0] S_RA    = 4'd3;
    localparam logic [3:0] S_RB    = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_WA    = 4'd6;
    localparam logic [3:0] S_WB    = 4'd7;
    localparam logic [3:0] S_ORD   = 4'd8;
    localparam logic [3:0] S_OSQ   = 4'd9;
    localparam logic [3:0] S_OSUM  = 4'd10;
    localparam logic [3:0] S_OSQRT = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    // twiddle rom, indexed at the largest transform size
    logic signed [TWB-1:0] tw_re_tab [NMAX];
    logic signed [TWB-1:0] tw_im_tab [NMAX];

    for (genvar k = 0; k < NMAX; k++)
    begin : g_tw
        localparam logic signed [TWB-1:0] TW_RE = TWB'(fms_tw(longint'(k), LGMAX, TWB, 1'b0));
        localparam logic signed [TWB-1:0] TW_IM = TWB'(fms_tw(longint'(k), LGMAX, TWB, 1'b1));
        assign tw_re_tab[k] = TW_RE;
        assign tw_im_tab[k] = TW_IM;
    end

    function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] x);
        logic [AW-1:0] r;
        for (int i = 0; i < AW; i++)
            r[i] = x[AW-1-i];
        return r;
    endfunction

    logic [3:0]            state_reg;
    logic [3:0]            state_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic [LG_W-1:0]       lg_reg;
    logic [LG_W-1:0]       lg_next;
    logic                  trunc_reg;
    logic                  trunc_next;
    logic [CNT_W-1:0]      pad_reg;
    logic [CNT_W-1:0]      pad_next;
    logic [LG_W-1:0]       stage_reg;
    logic [LG_W-1:0]       stage_next;
    logic [AW-1:0]         bf_reg;
    logic [AW-1:0]         bf_next;
    logic [AW-1:0]         bin_reg;
    logic [AW-1:0]         bin_next;
    logic [AW-1:0]         pa_reg;
    logic [AW-1:0]         pb_reg;
    logic signed [TWB-1:0] twr_reg;
    logic signed [TWB-1:0] twi_reg;
    store_t                ar_reg;
    store_t                ai_reg;
    logic signed [PW-1:0]  p_rr_reg;
    logic signed [PW-1:0]  p_ii_reg;
    logic signed [PW-1:0]  p_ri_reg;
    logic signed [PW-1:0]  p_ir_reg;
    store_t                dr_reg;
    store_t                di_reg;
    logic [SQ_W-1:0]       sq_re_reg;
    logic [SQ_W-1:0]       sq_im_reg;
    logic                  out_vld_reg;
    logic                  out_vld_next;
    logic [MAG_W-1:0]      mag_reg;
    logic [BIN_W-1:0]      obin_reg;
    logic                  ofinal_reg;
    logic                  otrunc_reg;

    logic                  in_xfer;
    logic                  out_xfer;
    logic [LG_W-1:0]       lg_calc;
    logic [CNT_W-1:0]      n_calc;
    logic [CNT_W-1:0]      n_val;
    logic [CNT_W-1:0]      half_val;
    logic [AW-1:0]         hmask;
    logic [AW-1:0]         a_log;
    logic [AW-1:0]         b_log;
    logic [AW-1:0]         a_phys;
    logic [AW-1:0]         b_phys;
    logic [AW-1:0]         o_phys;
    logic [AW-1:0]         tw_idx;
    logic                  bin_final;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DW-1:0]         ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DW-1:0]         ram_rdata;
    store_t                rd_re;
    store_t                rd_im;

    logic signed [PW:0]    sum_r;
    logic signed [PW:0]    sum_i;
    logic signed [PW:0]    rnd_r;
    logic signed [PW:0]    rnd_i;
    wide_sum_t             vr;
    wide_sum_t             vi;

    logic                  sq_start;
    logic                  sq_done;
    logic [STORE_W-1:0]    sq_root;

    assign in_xfer  = frame.valid && frame.ready;
    assign out_xfer = spectrum.valid && spectrum.ready;

    assign rd_re = ram_rdata[DW-1:STORE_W];
    assign rd_im = ram_rdata[STORE_W-1:0];

    // transform size from the stored sample count
    always_comb
    begin
        lg_calc = '0;
        for (int k = 0; k < LGMAX; k++)
            if ((CNT_W'(1) << k) < cnt_reg)
                lg_calc = lg_calc + LG_W'(1);
        n_calc = CNT_W'(1) << lg_calc;
    end

    assign n_val     = CNT_W'(1) << lg_reg;
    assign half_val  = n_val >> 1;
    assign bin_final = CNT_W'(bin_reg) == half_val;

    // butterfly addressing: insert a zero bit at the span position
    assign hmask  = (AW'(1) << (stage_reg - LG_W'(1))) - AW'(1);
    assign a_log  = ((bf_reg & ~hmask) << 1) | (bf_reg & hmask);
    assign b_log  = a_log | (hmask + AW'(1));
    assign tw_idx = (bf_reg & hmask) << (LG_W'(LGMAX) - stage_reg);

    // samples sit in natural order, so logical index x lives at bit_rev(x)
    assign a_phys = bit_rev(a_log) >> (LG_W'(AW) - lg_reg);
    assign b_phys = bit_rev(b_log) >> (LG_W'(AW) - lg_reg);
    assign o_phys = bit_rev(bin_reg) >> (LG_W'(AW) - lg_reg);

    assign sum_r = (PW+1)'(p_rr_reg) - (PW+1)'(p_ii_reg);
    assign sum_i = (PW+1)'(p_ri_reg) + (PW+1)'(p_ir_reg);
    assign rnd_r = (sum_r + ((PW+1)'(1) <<< (TWB - 2))) >>> (TWB - 1);
    assign rnd_i = (sum_i + ((PW+1)'(1) <<< (TWB - 2))) >>> (TWB - 1);
    assign vr    = wide_sum_t'(rnd_r);
    assign vi    = wide_sum_t'(rnd_i);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = o_phys;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_xfer && cnt_reg < CNT_W'(NMAX))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg[AW-1:0];
                    ram_wdata = {{(STORE_W-SAMPLE_W){frame.sample[SAMPLE_W-1]}},
                                 frame.sample, {STORE_W{1'b0}}};
                end
            end
            S_PAD:
            begin
                if (pad_reg < n_val)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pad_reg[AW-1:0];
                end
            end
            S_RA:
                ram_raddr = a_phys;
            S_RB:
                ram_raddr = b_phys;
            S_WA:
            begin
                ram_we    = 1'b1;
                ram_waddr = pa_reg;
                ram_wdata = {sat_store(wide_sum_t'(ar_reg) + vr),
                             sat_store(wide_sum_t'(ai_reg) + vi)};
            end
            S_WB:
            begin
                ram_we    = 1'b1;
                ram_waddr = pb_reg;
                ram_wdata = {dr_reg, di_reg};
            end
            default:
                ram_raddr = o_phys;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        lg_next      = lg_reg;
        trunc_next   = trunc_reg;
        pad_next     = pad_reg;
        stage_next   = stage_reg;
        bf_next      = bf_reg;
        bin_next     = bin_reg;
        out_vld_next = out_vld_reg;
        sq_start     = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_xfer)
                begin
                    if (cnt_reg < CNT_W'(MAX_POINTS))
                        cnt_next = cnt_reg + CNT_W'(1);
                    else
                        ovf_next = 1'b1;
                    if (frame.last)
                        state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                lg_next    = lg_calc;
                trunc_next = ovf_reg || (cnt_reg > n_calc);
                pad_next   = cnt_reg;
                state_next = S_PAD;
            end
            S_PAD:
            begin
                if (pad_reg < n_val)
                    pad_next = pad_reg + CNT_W'(1);
                else if (lg_reg == '0)
                begin
                    bin_next   = '0;
                    state_next = S_ORD;
                end
                else
                begin
                    stage_next = LG_W'(1);
                    bf_next    = '0;
                    state_next = S_RA;
                end
            end
            S_RA:
                state_next = S_RB;
            S_RB:
                state_next = S_MUL;
            S_MUL:
                state_next = S_WA;
            S_WA:
                state_next = S_WB;
            S_WB:
            begin
                state_next = S_RA;
                if (bf_reg == AW'(half_val - CNT_W'(1)))
                begin
                    bf_next = '0;
                    if (stage_reg == lg_reg)
                    begin
                        bin_next   = '0;
                        state_next = S_ORD;
                    end
                    else
                        stage_next = stage_reg + LG_W'(1);
                end
                else
                    bf_next = bf_reg + AW'(1);
            end
            S_ORD:
                state_next = S_OSQ;
            S_OSQ:
                state_next = S_OSUM;
            S_OSUM:
            begin
                sq_start   = 1'b1;
                state_next = S_OSQRT;
            end
            S_OSQRT:
            begin
                if (sq_done)
                begin
                    out_vld_next = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_xfer)
                begin
                    out_vld_next = 1'b0;
                    if (bin_final)
                    begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        bin_next   = bin_reg + AW'(1);
                        state_next = S_ORD;
                    end
                end
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            lg_reg      <= '0;
            trunc_reg   <= 1'b0;
            pad_reg     <= '0;
            stage_reg   <= '0;
            bf_reg      <= '0;
            bin_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            lg_reg      <= lg_next;
            trunc_reg   <= trunc_next;
            pad_reg     <= pad_next;
            stage_reg   <= stage_next;
            bf_reg      <= bf_next;
            bin_reg     <= bin_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RA)
            pa_reg <= a_phys;
        if (state_reg == S_RB)
        begin
            pb_reg  <= b_phys;
            twr_reg <= tw_re_tab[tw_idx];
            twi_reg <= tw_im_tab[tw_idx];
            ar_reg  <= rd_re;
            ai_reg  <= rd_im;
        end
        if (state_reg == S_MUL)
        begin
            p_rr_reg <= PW'(rd_re) * PW'(twr_reg);
            p_ii_reg <= PW'(rd_im) * PW'(twi_reg);
            p_ri_reg <= PW'(rd_re) * PW'(twi_reg);
            p_ir_reg <= PW'(rd_im) * PW'(twr_reg);
        end
        if (state_reg == S_WA)
        begin
            dr_reg <= sat_store(wide_sum_t'(ar_reg) - vr);
            di_reg <= sat_store(wide_sum_t'(ai_reg) - vi);
        end
        if (state_reg == S_OSQ)
        begin
            sq_re_reg <= SQ_W'(SQ_W'(rd_re) * SQ_W'(rd_re));
            sq_im_reg <= SQ_W'(SQ_W'(rd_im) * SQ_W'(rd_im));
        end
        if (state_reg == S_OSQRT && sq_done)
        begin
            mag_reg    <= sq_root[STORE_W-1] ? {MAG_W{1'b1}} : sq_root[MAG_W-1:0];
            obin_reg   <= BIN_W'(bin_reg);
            ofinal_reg <= bin_final;
            otrunc_reg <= trunc_reg;
        end
    end

    fms_ram #(
        .WIDTH (DW),
        .DEPTH (NMAX)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fms_isqrt #(
        .IN_W (SQ_W)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (sq_re_reg + sq_im_reg),
        .done  (sq_done),
        .root  (sq_root)
    );

    assign frame.ready        = state_reg == S_LOAD;
    assign spectrum.valid     = out_vld_reg;
    assign spectrum.magnitude = mag_reg;
    assign spectrum.bin       = obin_reg;
    assign spectrum.final_bin = ofinal_reg;
    assign spectrum.truncated = otrunc_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(frame.ready && spectrum.valid))
        else $error("input taken while a bin is pending");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && frame.last) |=> !frame.ready)
        else $error("frame not closed after last sample");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_POINTS))
        else $error("sample count beyond capacity");

    a_final_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && spectrum.final_bin) |=> (frame.ready && cnt_reg == '0 && !ovf_reg))
        else $error("frame state not cleared after final bin");

endmodule

// ----- tb/sv/fft_magnitude_spectrum_unit_tb.sv -----
// fft_magnitude_spectrum_unit_tb: drives real sample frames into the fft magnitude unit
// and checks every spectrum bin against a fixed-point fft predictor.
// Depends on fms_pkg, fms_sample_if, fms_bin_if and the design under test.
`timescale 1ns / 1ps

module fft_magnitude_spectrum_unit_tb;
    import fms_pkg::*;

    localparam int     MAX_PTS     = 64;
    localparam int     TW_BITS     = 16;
    localparam int     ITEM_GOAL   = 380;
    localparam int     CYCLE_LIMIT = 600000;
    localparam int     TAIL_CYCLES = 200;
    localparam longint HALF_PI     = 64'sd1686629713;
    localparam longint ONE_Q30     = longint'(1) << 30;
    localparam longint ST_MAX      = (longint'(1) << 22) - 1;
    localparam longint ST_MIN      = -(longint'(1) << 22);
    localparam longint MAG_SAT     = (longint'(1) << 22) - 1;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        bit                         drain_first;
    } sample_item_t;

    typedef struct {
        logic [MAG_W-1:0] magnitude;
        logic [BIN_W-1:0] bin;
        logic             final_bin;
        logic             truncated;
    } bin_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fms_sample_if frame_ch();
    fms_bin_if    spec_ch();

    logic                       drv_valid = 1'b0;
    logic signed [SAMPLE_W-1:0] drv_sample = '0;
    logic                       drv_last = 1'b0;
    logic                       rcv_ready = 1'b0;

    assign frame_ch.valid  = drv_valid;
    assign frame_ch.sample = drv_sample;
    assign frame_ch.last   = drv_last;
    assign spec_ch.ready   = rcv_ready;

    fft_magnitude_spectrum_unit #(
        .MAX_POINTS  (MAX_PTS),
        .TWIDDLE_BITS(TW_BITS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame   (frame_ch),
        .spectrum(spec_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sample_item_t pending_samples[$];
    bin_result_t  expected_bins[$];

    // predictor state
    longint fft_re[MAX_PTS];
    longint fft_im[MAX_PTS];
    int     held_count = 0;
    bit     dropped_seen = 1'b0;

    int  mismatches = 0;
    int  bins_checked = 0;
    int  frames_sent = 0;
    int  trunc_frames = 0;
    int  cycle_count = 0;
    bit  stim_done = 1'b0;

    function automatic longint round_q(input longint x, input int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint to_tw(input longint q30);
        longint lim;
        lim = longint'(1) << (TW_BITS - 1);
        return clip(round_q(q30, 30 - (TW_BITS - 1)), -lim, lim - 1);
    endfunction

    // W(k) = cos - i sin of 2*pi*k/n, quadrant folded, taylor series in q30
    task automatic twiddle_of(input longint k, input longint n,
                              output longint wr, output longint wi);
        longint quad;
        longint rem;
        longint phi;
        longint x2;
        longint ts;
        longint tc;
        longint ss;
        longint cc;
        quad = (4 * k) / n;
        rem  = (4 * k) % n;
        phi  = (HALF_PI * rem) / n;
        x2   = (phi * phi) / ONE_Q30;
        ts   = phi;
        tc   = ONE_Q30;
        ss   = phi;
        cc   = ONE_Q30;
        for (longint t = 1; t <= 10; t++)
        begin
            tc = (-tc * x2) / ONE_Q30 / ((2 * t - 1) * (2 * t));
            cc += tc;
            ts = (-ts * x2) / ONE_Q30 / ((2 * t) * (2 * t + 1));
            ss += ts;
        end
        if (quad == 0)
        begin
            wr = to_tw(cc);
            wi = to_tw(-ss);
        end
        else
        begin
            wr = to_tw(-ss);
            wi = to_tw(-cc);
        end
    endtask

    function automatic longint int_sqrt(input longint v);
        longint res;
        longint b;
        res = 0;
        b   = longint'(1) << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic compute_spectrum();
        int          n;
        int          lg;
        int          rv;
        int          h;
        bit          trunc;
        longint      tmp;
        longint      wr;
        longint      wi;
        longint      vr;
        longint      vi;
        longint      ur;
        longint      ui;
        longint      ar;
        longint      ai;
        bin_result_t res;
        n     = 1;
        lg    = 0;
        trunc = dropped_seen;
        while (n < held_count && n < MAX_PTS)
        begin
            n  = n * 2;
            lg = lg + 1;
        end
        if (held_count > n)
            trunc = 1'b1;
        for (int i = held_count; i < n; i++)
        begin
            fft_re[i] = 0;
            fft_im[i] = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            rv = 0;
            for (int b = 0; b < lg; b++)
                rv |= ((i >> b) & 1) << (lg - 1 - b);
            if (rv > i)
            begin
                tmp = fft_re[i]; fft_re[i] = fft_re[rv]; fft_re[rv] = tmp;
                tmp = fft_im[i]; fft_im[i] = fft_im[rv]; fft_im[rv] = tmp;
            end
        end
        for (int len = 2; len <= n; len *= 2)
        begin
            h = len / 2;
            for (int i = 0; i < n; i += len)
            begin
                for (int j = 0; j < h; j++)
                begin
                    twiddle_of(j * (n / len), n, wr, wi);
                    vr = round_q(fft_re[i+j+h] * wr - fft_im[i+j+h] * wi, TW_BITS - 1);
                    vi = round_q(fft_re[i+j+h] * wi + fft_im[i+j+h] * wr, TW_BITS - 1);
                    ur = fft_re[i+j];
                    ui = fft_im[i+j];
                    fft_re[i+j]   = clip(ur + vr, ST_MIN, ST_MAX);
                    fft_im[i+j]   = clip(ui + vi, ST_MIN, ST_MAX);
                    fft_re[i+j+h] = clip(ur - vr, ST_MIN, ST_MAX);
                    fft_im[i+j+h] = clip(ui - vi, ST_MIN, ST_MAX);
                end
            end
        end
        for (int i = 0; i <= n / 2; i++)
        begin
            ar  = (fft_re[i] < 0) ? -fft_re[i] : fft_re[i];
            ai  = (fft_im[i] < 0) ? -fft_im[i] : fft_im[i];
            tmp = int_sqrt(ar * ar + ai * ai);
            if (tmp > MAG_SAT)
                tmp = MAG_SAT;
            res.magnitude = tmp[MAG_W-1:0];
            res.bin       = i[BIN_W-1:0];
            res.final_bin = (i == n / 2);
            res.truncated = trunc;
            expected_bins.push_back(res);
        end
        if (trunc)
            trunc_frames++;
        frames_sent++;
        held_count   = 0;
        dropped_seen = 1'b0;
    endtask

    task automatic accept_sample(input sample_item_t it);
        if (held_count < MAX_PTS)
        begin
            fft_re[held_count] = longint'(it.sample);
            fft_im[held_count] = 0;
            held_count++;
        end
        else
            dropped_seen = 1'b1;
        if (it.last)
            compute_spectrum();
    endtask

    task automatic queue_frame(input int len, input int style, input bit drain);
        sample_item_t it;
        for (int i = 0; i < len; i++)
        begin
            case (style)
                0: it.sample = SAMPLE_W'($urandom);
                1: it.sample = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
                2: it.sample = $signed(16'($urandom_range(0, 63))) - 16'sd32;
                default: it.sample = (i % 2 == 0) ? 16'sh7fff : 16'sh8000;
            endcase
            it.last        = (i == len - 1);
            it.drain_first = drain && (i == 0);
            pending_samples.push_back(it);
        end
    endtask

    initial
    begin
        int queued;
        int len;
        int pick;
        bit drain_done;
        drain_done = 1'b0;
        // directed: single point, two points, padding, full-scale extremes
        queue_frame(1, 1, 1'b0);
        queue_frame(2, 3, 1'b0);
        queue_frame(3, 0, 1'b0);
        queue_frame(5, 3, 1'b0);
        queue_frame(8, 2, 1'b0);
        queued = 19;
        while (queued < ITEM_GOAL)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                len = $urandom_range(1, 16);
            else if (pick < 92)
                len = $urandom_range(17, MAX_PTS);
            else
                len = $urandom_range(MAX_PTS + 1, MAX_PTS + 12);
            queue_frame(len, $urandom_range(0, 3), queued > 150 && !drain_done);
            if (queued > 150)
                drain_done = 1'b1;
            queued += len;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // sender: bursts with random gaps, optional drain before a frame
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid  <= 1'b0;
            drv_sample <= '0;
            drv_last   <= 1'b0;
        end
        else
        begin : drive
            bit hold;
            hold = drv_valid && !frame_ch.ready;
            if (drv_valid && frame_ch.ready)
            begin
                accept_sample(pending_samples[0]);
                pending_samples.pop_front();
            end
            if (!hold)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    drv_valid <= 1'b0;
                end
                else if (pending_samples.size() > 0 &&
                         (!pending_samples[0].drain_first || expected_bins.size() == 0))
                begin
                    drv_valid  <= 1'b1;
                    drv_sample <= pending_samples[0].sample;
                    drv_last   <= pending_samples[0].last;
                    pending_samples[0].drain_first = 1'b0;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    drv_valid <= 1'b0;
                    if (pending_samples.size() == 0)
                        stim_done = 1'b1;
                end
            end
        end
    end

    // receiver: own stall pattern plus one long hold-off
    int long_hold = 0;
    bit long_hold_done = 1'b0;
    int stall_mode = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rcv_ready <= 1'b0;
        else
        begin : monitor
            bin_result_t exp_bin;
            bit          nr;
            if (spec_ch.valid && rcv_ready)
            begin
                bins_checked++;
                if (expected_bins.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected bin transfer: bin %0d mag %0d",
                                 spec_ch.bin, spec_ch.magnitude);
                end
                else
                begin
                    exp_bin = expected_bins.pop_front();
                    if (spec_ch.magnitude !== exp_bin.magnitude || spec_ch.bin !== exp_bin.bin ||
                        spec_ch.final_bin !== exp_bin.final_bin ||
                        spec_ch.truncated !== exp_bin.truncated)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("bin mismatch: exp mag %0d bin %0d fin %0b tr %0b",
                                     exp_bin.magnitude, exp_bin.bin, exp_bin.final_bin,
                                     exp_bin.truncated);
                            $display("              got mag %0d bin %0d fin %0b tr %0b",
                                     spec_ch.magnitude, spec_ch.bin, spec_ch.final_bin,
                                     spec_ch.truncated);
                        end
                    end
                end
                if (bins_checked == 60 && !long_hold_done)
                begin
                    long_hold      = 3000;
                    long_hold_done = 1'b1;
                end
            end
            if ($urandom_range(0, 63) == 0)
                stall_mode = $urandom_range(0, 2);
            if (long_hold > 0)
            begin
                long_hold--;
                nr = 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0: nr = 1'b1;
                    1: nr = ($urandom_range(0, 3) != 0);
                    default: nr = ($urandom_range(0, 3) == 0);
                endcase
            end
            rcv_ready <= nr;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d, %0d bins outstanding", cycle_count,
                     expected_bins.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        wait (stim_done);
        wait (expected_bins.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d frames (%0d truncated), %0d bins checked, %0d mismatches",
                 frames_sent, trunc_frames, bins_checked, mismatches);
        if (mismatches == 0 && expected_bins.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
